### sv/aabb_pkg.sv
// Shared types, widths and a saturation helper for the box collision block.
`timescale 1ns / 1ps
package aabb_pkg;
    localparam int COORD_W = 32;
    localparam int SIZE_W  = 31;
    localparam int IMASS_W = 24;
    localparam int SUM_W   = IMASS_W + 1;
    localparam int DVD_W   = 58;
    localparam int DVS_W   = 29;
    localparam int QUO_W   = COORD_W - 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_VX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_VY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_W     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_H     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IMASS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd7;

    localparam logic CMD_COLLIDE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] other_left;
        logic signed [COORD_W-1:0] other_top;
        logic signed [COORD_W-1:0] other_right;
        logic signed [COORD_W-1:0] other_bottom;
        logic signed [COORD_W-1:0] other_vel_x;
        logic signed [COORD_W-1:0] other_vel_y;
        logic [IMASS_W-1:0]        other_inverse_mass;
    } in_item_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] delta_vel_x;
        logic signed [COORD_W-1:0] delta_vel_y;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
    } out_item_t;

    // saturate a 34-bit signed sum to the 32-bit range
    function automatic logic signed [COORD_W-1:0] sat34(input logic signed [COORD_W+1:0] v);
        logic signed [COORD_W+1:0] hi;
        logic signed [COORD_W+1:0] lo;
        hi = {3'b000, {(COORD_W-1){1'b1}}};
        lo = {3'b111, {(COORD_W-1){1'b0}}};
        if (v > hi) begin
            sat34 = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v < lo) begin
            sat34 = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat34 = v[COORD_W-1:0];
        end
    endfunction
endpackage

### sv/aabb_div.sv
// Serial restoring divider: 31-bit quotient with an overflow flag, one bit per cycle.
`timescale 1ns / 1ps
module aabb_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [aabb_pkg::DVD_W-1:0]    dividend,
    input  logic [aabb_pkg::DVS_W-1:0]    divisor,
    output logic                          done,
    output logic                          over,
    output logic [aabb_pkg::QUO_W-1:0]    quotient
);
    localparam int DEN_W = aabb_pkg::DVS_W + aabb_pkg::QUO_W;
    localparam int CNT_W = $clog2(aabb_pkg::QUO_W + 1);

    logic [aabb_pkg::DVD_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0]           den_reg, den_next;
    logic [aabb_pkg::QUO_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       run_reg, run_next;
    logic                       over_reg, over_next;
    logic                       done_reg, done_next;
    logic                       ge;

    assign ge = {{(DEN_W - aabb_pkg::DVD_W){1'b0}}, rem_reg} >= den_reg;

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        over_next = over_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            den_next  = {divisor, {aabb_pkg::QUO_W{1'b0}}};
            q_next    = '0;
            cnt_next  = CNT_W'(aabb_pkg::QUO_W);
            run_next  = 1'b1;
            over_next = 1'b0;
        end else if (run_reg) begin
            // top step only tests for a quotient beyond 31 bits
            if (cnt_reg == CNT_W'(aabb_pkg::QUO_W)) begin
                over_next = ge;
            end else begin
                if (ge) begin
                    rem_next = rem_reg - den_reg[aabb_pkg::DVD_W-1:0];
                end
                q_next = {q_reg[aabb_pkg::QUO_W-2:0], ge};
            end
            den_next = den_reg >> 1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        over_reg <= over_next;
    end

    assign done     = done_reg;
    assign over     = over_reg;
    assign quotient = q_reg;
endmodule

### sv/aabb_collision_impulse_step.sv
// Box collision and impulse step: one kept box, overlap test, impulse, tick move.
// Collide item with an impulse: geometry steps, multiply, two serial divisions on one
//   shared divider, finish. Collide item without an impulse: geometry, multiply, finish.
//   Tick item: straight to finish. A held result stalls the block in finish. One item at
//   a time; input is taken again once the result is latched.
// Synchronous active-low reset loads register defaults and clears the FSM and kept state.
`timescale 1ns / 1ps
module aabb_collision_impulse_step (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  aabb_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output aabb_pkg::out_item_t                   m_data,
    input  logic                                  cfg_wr_en,
    input  logic [aabb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [aabb_pkg::COORD_W-1:0]          cfg_wr_data
);
    localparam int CW = aabb_pkg::COORD_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_GEO1  = 4'd1;
    localparam logic [3:0] ST_GEO2  = 4'd2;
    localparam logic [3:0] ST_GEO3  = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_DIV1S = 4'd5;
    localparam logic [3:0] ST_DIV1W = 4'd6;
    localparam logic [3:0] ST_DIV2S = 4'd7;
    localparam logic [3:0] ST_DIV2W = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    logic [3:0] state_reg, state_next;

    // configuration and kept state
    logic [aabb_pkg::SIZE_W-1:0]  box_w_reg, box_h_reg;
    logic [aabb_pkg::IMASS_W-1:0] own_im_reg;
    logic [1:0]                   mode_reg;
    logic signed [CW-1:0] px_reg, py_reg, vx_reg, vy_reg, pushx_reg, pushy_reg;
    logic signed [CW-1:0] px_next, py_next, vx_next, vy_next, pushx_next, pushy_next;

    aabb_pkg::in_item_t in_reg;
    aabb_pkg::out_item_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;

    // pipeline of the collide work
    logic signed [35:0] nx2_reg, ny2_reg;
    logic signed [34:0] extx_reg, exty_reg;
    logic signed [32:0] rvx_reg, rvy_reg;
    logic signed [36:0] xov_reg, yov_reg;
    logic               hit_reg, go_reg, onx_reg, neg_reg;
    logic [33:0]        pen_reg;
    logic [32:0]        along_reg;
    logic [aabb_pkg::SUM_W-1:0] sum_reg;
    logic [aabb_pkg::DVD_W-1:0] prodv_reg, prodp_reg;
    logic [aabb_pkg::DVS_W-1:0] sum10_reg;
    logic [aabb_pkg::QUO_W-1:0] qv_reg, qp_reg;
    logic               ovv_reg, ovp_reg;

    logic                       div_start, div_done, div_over;
    logic [aabb_pkg::DVD_W-1:0] div_dvd;
    logic [aabb_pkg::DVS_W-1:0] div_dvs;
    logic [aabb_pkg::QUO_W-1:0] div_q;

    assign div_start = (state_reg == ST_DIV1S) || (state_reg == ST_DIV2S);
    assign div_dvd   = (state_reg == ST_DIV1S) ? prodv_reg : prodp_reg;
    assign div_dvs   = (state_reg == ST_DIV1S)
                       ? {{(aabb_pkg::DVS_W - aabb_pkg::SUM_W){1'b0}}, sum_reg} : sum10_reg;

    aabb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .over     (div_over),
        .quotient (div_q)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // geometry stage 1
    logic signed [35:0] nx2_c, ny2_c;
    logic signed [34:0] extx_c, exty_c;
    always_comb begin
        nx2_c = 36'(px_reg) + 36'(px_reg) + 36'($signed({1'b0, box_w_reg}))
              - 36'(in_reg.other_left) - 36'(in_reg.other_right);
        ny2_c = 36'(py_reg) + 36'(py_reg) - 36'($signed({1'b0, box_h_reg}))
              - 36'(in_reg.other_top) - 36'(in_reg.other_bottom);
        extx_c = 35'($signed({1'b0, box_w_reg})) + 35'(in_reg.other_right)
               - 35'(in_reg.other_left);
        exty_c = 35'($signed({1'b0, box_h_reg})) + 35'(in_reg.other_top)
               - 35'(in_reg.other_bottom);
    end

    function automatic logic [aabb_pkg::SUM_W-1:0] SUM_W_EXT(
        input logic [aabb_pkg::IMASS_W-1:0] v);
        SUM_W_EXT = {1'b0, v};
    endfunction

    // geometry stage 3 selection
    logic               hit_c, onx_c, neg_c;
    logic signed [32:0] rv_c;
    logic signed [33:0] along_c;
    logic [aabb_pkg::SUM_W-1:0] sum_c;
    always_comb begin
        hit_c   = (xov_reg > 37'sd0) && (yov_reg > 37'sd0);
        onx_c   = xov_reg < yov_reg;
        neg_c   = onx_c ? nx2_reg[35] : ny2_reg[35];
        rv_c    = onx_c ? rvx_reg : rvy_reg;
        along_c = neg_c ? -34'(rv_c) : 34'(rv_c);
        sum_c   = SUM_W_EXT(own_im_reg) + SUM_W_EXT(in_reg.other_inverse_mass);
    end

    // finish: signed deltas and state updates
    logic signed [CW-1:0] dmag_c, pmag_c, d_c, p_c;
    logic signed [CW-1:0] tx1_c, ty1_c;
    always_comb begin
        dmag_c = ovv_reg ? {1'b0, {(CW-1){1'b1}}} : $signed({1'b0, qv_reg});
        pmag_c = ovp_reg ? {1'b0, {(CW-1){1'b1}}} : $signed({1'b0, qp_reg});
        d_c    = neg_reg ? -dmag_c : dmag_c;
        p_c    = neg_reg ? -pmag_c : pmag_c;
        tx1_c  = aabb_pkg::sat34(34'(px_reg) + 34'(pushx_reg));
        ty1_c  = aabb_pkg::sat34(34'(py_reg) + 34'(pushy_reg));
    end

    always_comb begin
        state_next   = state_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        pushx_next   = pushx_reg;
        pushy_next   = pushy_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_wr_en) begin
            unique case (cfg_index)
                aabb_pkg::REG_START_X:  px_next = cfg_wr_data;
                aabb_pkg::REG_START_Y:  py_next = cfg_wr_data;
                aabb_pkg::REG_START_VX: vx_next = cfg_wr_data;
                aabb_pkg::REG_START_VY: vy_next = cfg_wr_data;
                default: ;
            endcase
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.command == aabb_pkg::CMD_TICK) ? ST_FIN : ST_GEO1;
                end
            end
            ST_GEO1:  state_next = ST_GEO2;
            ST_GEO2:  state_next = ST_GEO3;
            ST_GEO3:  state_next = ST_MUL;
            ST_MUL:   state_next = go_reg ? ST_DIV1S : ST_FIN;
            ST_DIV1S: state_next = ST_DIV1W;
            ST_DIV1W: if (div_done) begin
                state_next = ST_DIV2S;
            end
            ST_DIV2S: state_next = ST_DIV2W;
            ST_DIV2W: if (div_done) begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next             = '0;
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                    if (in_reg.command == aabb_pkg::CMD_TICK) begin
                        if (!mode_reg[1]) begin
                            px_next = aabb_pkg::sat34(34'(tx1_c) + 34'(vx_reg));
                            py_next = aabb_pkg::sat34(34'(ty1_c) + 34'(vy_reg));
                        end
                        pushx_next = '0;
                        pushy_next = '0;
                    end else begin
                        out_next.hit = hit_reg;
                        if (go_reg) begin
                            if (onx_reg) begin
                                out_next.delta_vel_x = d_c;
                                vx_next    = aabb_pkg::sat34(34'(vx_reg) + 34'(d_c));
                                pushx_next = aabb_pkg::sat34(34'(pushx_reg) + 34'(p_c));
                            end else begin
                                out_next.delta_vel_y = d_c;
                                vy_next    = aabb_pkg::sat34(34'(vy_reg) + 34'(d_c));
                                pushy_next = aabb_pkg::sat34(34'(pushy_reg) + 34'(p_c));
                            end
                        end
                    end
                    out_next.pos_x = px_next;
                    out_next.pos_y = py_next;
                    out_next.vel_x = vx_next;
                    out_next.vel_y = vy_next;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            box_w_reg   <= 31'd1048576;
            box_h_reg   <= 31'd1048576;
            own_im_reg  <= 24'd65536;
            mode_reg    <= 2'd1;
            px_reg      <= '0;
            py_reg      <= '0;
            vx_reg      <= '0;
            vy_reg      <= '0;
            pushx_reg   <= '0;
            pushy_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            vx_reg      <= vx_next;
            vy_reg      <= vy_next;
            pushx_reg   <= pushx_next;
            pushy_reg   <= pushy_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    aabb_pkg::REG_BOX_W:     box_w_reg  <= cfg_wr_data[aabb_pkg::SIZE_W-1:0];
                    aabb_pkg::REG_BOX_H:     box_h_reg  <= cfg_wr_data[aabb_pkg::SIZE_W-1:0];
                    aabb_pkg::REG_OWN_IMASS: own_im_reg <= cfg_wr_data[aabb_pkg::IMASS_W-1:0];
                    aabb_pkg::REG_MODE:      mode_reg   <= cfg_wr_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_GEO1) begin
            nx2_reg  <= nx2_c;
            ny2_reg  <= ny2_c;
            extx_reg <= extx_c;
            exty_reg <= exty_c;
            rvx_reg  <= 33'(in_reg.other_vel_x) - 33'(vx_reg);
            rvy_reg  <= 33'(in_reg.other_vel_y) - 33'(vy_reg);
        end
        if (state_reg == ST_GEO2) begin
            xov_reg <= 37'(extx_reg) - 37'(nx2_reg[35] ? -nx2_reg : nx2_reg);
            yov_reg <= 37'(exty_reg) - 37'(ny2_reg[35] ? -ny2_reg : ny2_reg);
        end
        if (state_reg == ST_GEO3) begin
            hit_reg   <= hit_c;
            onx_reg   <= onx_c;
            neg_reg   <= neg_c;
            pen_reg   <= onx_c ? xov_reg[33:0] : yov_reg[33:0];
            along_reg <= along_c[32:0];
            sum_reg   <= sum_c;
            go_reg    <= hit_c && mode_reg[0] && !along_c[33] && (sum_c != '0);
        end
        if (state_reg == ST_MUL) begin
            prodv_reg <= aabb_pkg::DVD_W'(along_reg * own_im_reg);
            prodp_reg <= aabb_pkg::DVD_W'(pen_reg * own_im_reg);
            sum10_reg <= aabb_pkg::DVS_W'(sum_reg * 4'd10);
        end
        if (state_reg == ST_DIV1W && div_done) begin
            qv_reg  <= div_q;
            ovv_reg <= div_over;
        end
        if (state_reg == ST_DIV2W && div_done) begin
            qp_reg  <= div_q;
            ovp_reg <= div_over;
        end
    end
endmodule

### test/aabb_collision_impulse_step_tb.sv
// Testbench for the box collision and impulse step block: scoreboard prediction plus random traffic.
`timescale 1ns / 1ps
module aabb_collision_impulse_step_tb;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam int     CYCLE_LIMIT = 400000;

    class box_scoreboard;
        longint org_x, org_y, vel0_x, vel0_y;
        longint width, height, own_imass;
        logic [1:0] mode;
        longint px, py, vx, vy, push_x, push_y;
        aabb_pkg::out_item_t pending[$];
        int errors;

        function new();
            errors = 0;
            width = 1048576; height = 1048576; own_imass = 65536; mode = 2'b01;
            org_x = 0; org_y = 0; vel0_x = 0; vel0_y = 0;
            px = 0; py = 0; vx = 0; vy = 0; push_x = 0; push_y = 0;
        endfunction

        function longint clamp(longint v);
            if (v > SAT_HI) return SAT_HI;
            if (v < SAT_LO) return SAT_LO;
            return v;
        endfunction

        function void write_reg(logic [aabb_pkg::CFG_IDX_W-1:0] idx,
                                logic [aabb_pkg::COORD_W-1:0] d);
            longint s;
            s = longint'(signed'(d));
            case (idx)
                aabb_pkg::REG_START_X:   begin org_x = s; px = s; end
                aabb_pkg::REG_START_Y:   begin org_y = s; py = s; end
                aabb_pkg::REG_START_VX:  begin vel0_x = s; vx = s; end
                aabb_pkg::REG_START_VY:  begin vel0_y = s; vy = s; end
                aabb_pkg::REG_BOX_W:     width = longint'(d[30:0]);
                aabb_pkg::REG_BOX_H:     height = longint'(d[30:0]);
                aabb_pkg::REG_OWN_IMASS: own_imass = longint'(d[23:0]);
                aabb_pkg::REG_MODE:      mode = d[1:0];
                default: ;
            endcase
        endfunction

        function void note_input(aabb_pkg::in_item_t it);
            aabb_pkg::out_item_t r;
            longint ol, ot, orr, ob, oim, nx2, ny2, xov2, yov2, pen2, sgn, along, sum, d, p;
            bit on_x;
            r = '0;
            if (it.command == aabb_pkg::CMD_TICK) begin
                if (!mode[1]) begin
                    px = clamp(px + push_x); py = clamp(py + push_y);
                    px = clamp(px + vx); py = clamp(py + vy);
                end
                push_x = 0; push_y = 0;
            end else begin
                ol = longint'(it.other_left); ot = longint'(it.other_top);
                orr = longint'(it.other_right); ob = longint'(it.other_bottom);
                oim = longint'(it.other_inverse_mass);
                nx2 = (2 * px + width) - (ol + orr);
                ny2 = (2 * py - height) - (ot + ob);
                xov2 = width + (orr - ol) - (nx2 < 0 ? -nx2 : nx2);
                yov2 = height + (ot - ob) - (ny2 < 0 ? -ny2 : ny2);
                if (xov2 > 0 && yov2 > 0) begin
                    on_x = xov2 < yov2;
                    pen2 = on_x ? xov2 : yov2;
                    sgn = on_x ? (nx2 < 0 ? -1 : 1) : (ny2 < 0 ? -1 : 1);
                    r.hit = 1'b1;
                    if (mode[0]) begin
                        along = (on_x ? (longint'(it.other_vel_x) - vx)
                                      : (longint'(it.other_vel_y) - vy)) * sgn;
                        sum = own_imass + oim;
                        if (along >= 0 && sum != 0) begin
                            d = clamp((along * own_imass) / sum) * sgn;
                            p = clamp((pen2 * own_imass) / (sum * 10)) * sgn;
                            if (on_x) begin
                                r.delta_vel_x = 32'(d);
                                vx = clamp(vx + d); push_x = clamp(push_x + p);
                            end else begin
                                r.delta_vel_y = 32'(d);
                                vy = clamp(vy + d); push_y = clamp(push_y + p);
                            end
                        end
                    end
                end
            end
            r.pos_x = 32'(px); r.pos_y = 32'(py); r.vel_x = 32'(vx); r.vel_y = 32'(vy);
            pending.push_back(r);
        endfunction

        function void check_result(aabb_pkg::out_item_t got);
            aabb_pkg::out_item_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.hit !== e.hit) begin
                $display("%0t: hit exp %0d got %0d", $time, e.hit, got.hit); errors++;
            end
            if (got.delta_vel_x !== e.delta_vel_x) begin
                $display("%0t: delta_vel_x exp %0d got %0d", $time, e.delta_vel_x,
                         got.delta_vel_x); errors++;
            end
            if (got.delta_vel_y !== e.delta_vel_y) begin
                $display("%0t: delta_vel_y exp %0d got %0d", $time, e.delta_vel_y,
                         got.delta_vel_y); errors++;
            end
            if (got.pos_x !== e.pos_x) begin
                $display("%0t: pos_x exp %0d got %0d", $time, e.pos_x, got.pos_x); errors++;
            end
            if (got.pos_y !== e.pos_y) begin
                $display("%0t: pos_y exp %0d got %0d", $time, e.pos_y, got.pos_y); errors++;
            end
            if (got.vel_x !== e.vel_x) begin
                $display("%0t: vel_x exp %0d got %0d", $time, e.vel_x, got.vel_x); errors++;
            end
            if (got.vel_y !== e.vel_y) begin
                $display("%0t: vel_y exp %0d got %0d", $time, e.vel_y, got.vel_y); errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    aabb_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    aabb_pkg::out_item_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [aabb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [aabb_pkg::COORD_W-1:0] cfg_wr_data = '0;

    box_scoreboard sb;
    int cycles = 0;
    bit stall_sink = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    aabb_collision_impulse_step u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    // result side: check and stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (stall_sink) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0) || (cycles[9:7] == 3'd2);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(signed'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(logic [aabb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
        @(posedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wr_data <= d;
        sb.write_reg(idx, d);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(aabb_pkg::in_item_t it);
        @(posedge aclk);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        s_valid <= 1'b0;
    endtask

    // near-overlap collide item around the kept box so hits are common
    function automatic aabb_pkg::in_item_t near_box();
        aabb_pkg::in_item_t it;
        int spread;
        longint cx, cy, w, h;
        spread = $urandom_range(1, 40) << 16;
        w = $urandom_range(1, 32) << 16;
        h = $urandom_range(1, 32) << 16;
        cx = sb.px + longint'($urandom_range(0, 2 * spread)) - spread;
        cy = sb.py - longint'($urandom_range(0, 2 * spread)) + spread;
        it = '0;
        it.command = aabb_pkg::CMD_COLLIDE;
        it.other_left = 32'(sb.clamp(cx));
        it.other_top = 32'(sb.clamp(cy));
        it.other_right = 32'(sb.clamp(cx + w));
        it.other_bottom = 32'(sb.clamp(cy - h));
        if ($urandom_range(0, 9) == 0) it.other_right = 32'(sb.clamp(cx - w));
        if ($urandom_range(0, 9) == 0) it.other_bottom = 32'(sb.clamp(cy + h));
        it.other_vel_x = 32'(signed'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
        it.other_vel_y = 32'(signed'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
        if ($urandom_range(0, 7) == 0) it.other_vel_x = pick_word();
        if ($urandom_range(0, 7) == 0) it.other_vel_y = pick_word();
        case ($urandom_range(0, 5))
            0: it.other_inverse_mass = '0;
            1: it.other_inverse_mass = '1;
            default: it.other_inverse_mass = 24'($urandom_range(0, 24'h03_FFFF));
        endcase
        return it;
    endfunction

    function automatic aabb_pkg::in_item_t rand_item();
        aabb_pkg::in_item_t it;
        int k;
        k = $urandom_range(0, 9);
        if (k < 3) begin
            it = '0;
            it.command = aabb_pkg::CMD_TICK;
            if (k == 0) it[215:0] = 216'({$urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom, $urandom});
        end else if (k < 9) begin
            it = near_box();
        end else begin
            it = {1'b0, pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                  pick_word(), 24'($urandom)};
        end
        return it;
    endfunction

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                if (n > 0) send_item(rand_item());
                n--;
            end
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 90)) @(posedge aclk);
        end
    endtask

    initial begin
        aabb_pkg::in_item_t it;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset defaults, overlaps on each axis, extremes
        it = '0; it.command = aabb_pkg::CMD_TICK; send_item(it);
        it = '0; it.command = aabb_pkg::CMD_COLLIDE;
        it.other_left = 32'sh0008_0000; it.other_right = 32'sh0018_0000;
        it.other_top = 32'sh0002_0000; it.other_bottom = -32'sh000E_0000;
        it.other_vel_x = -32'sh0001_0000; it.other_inverse_mass = 24'h01_0000;
        send_item(it);
        it.other_left = 32'sh0002_0000; it.other_right = 32'sh000E_0000;
        it.other_top = -32'sh0008_0000; it.other_bottom = -32'sh0018_0000;
        it.other_vel_y = 32'sh0003_0000; send_item(it);
        it.other_inverse_mass = '0; send_item(it);
        it.other_vel_y = -32'sh0003_0000; send_item(it);
        it.other_right = -32'sh0010_0000; send_item(it);
        it = '0; it.command = aabb_pkg::CMD_TICK; send_item(it);
        it = {1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF};
        send_item(it);
        it = {1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0000};
        send_item(it);
        it = '1; send_item(it);
        drain();

        // zero own inverse mass and not-solid settings
        write_reg(aabb_pkg::REG_OWN_IMASS, 32'd0);
        repeat (10) send_item(near_box());
        drain();
        write_reg(aabb_pkg::REG_OWN_IMASS, 32'h00FF_FFFF);
        write_reg(aabb_pkg::REG_MODE, 32'd0);
        phase(10);
        drain();

        // extremes of the start state and size, pinned and solid
        write_reg(aabb_pkg::REG_START_X, 32'h7FFF_F000);
        write_reg(aabb_pkg::REG_START_Y, 32'h8000_0000);
        write_reg(aabb_pkg::REG_START_VX, 32'h7FFF_FFFF);
        write_reg(aabb_pkg::REG_START_VY, 32'h8000_0000);
        write_reg(aabb_pkg::REG_BOX_W, 32'h7FFF_FFFF);
        write_reg(aabb_pkg::REG_BOX_H, 32'd0);
        write_reg(aabb_pkg::REG_MODE, 32'd3);
        phase(40);
        drain();
        write_reg(aabb_pkg::REG_MODE, 32'd1);
        phase(30);
        drain();

        // long receiver hold-off while items keep coming
        write_reg(aabb_pkg::REG_START_X, 32'd0); write_reg(aabb_pkg::REG_START_Y, 32'd0);
        write_reg(aabb_pkg::REG_START_VX, 32'd0); write_reg(aabb_pkg::REG_START_VY, 32'd0);
        write_reg(aabb_pkg::REG_BOX_W, 32'h0010_0000);
        write_reg(aabb_pkg::REG_BOX_H, 32'h0010_0000);
        write_reg(aabb_pkg::REG_OWN_IMASS, 32'h0001_0000);
        stall_sink = 1'b1;
        fork
            begin repeat (600) @(posedge aclk); stall_sink = 1'b0; end
            phase(20);
        join
        drain();

        // main random runs across several settings
        repeat (5) begin
            write_reg(aabb_pkg::REG_START_X,
                      $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
            write_reg(aabb_pkg::REG_START_Y,
                      $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
            write_reg(aabb_pkg::REG_START_VX,
                      $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            write_reg(aabb_pkg::REG_START_VY,
                      $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            write_reg(aabb_pkg::REG_BOX_W, $urandom_range(1, 48) << 16);
            write_reg(aabb_pkg::REG_BOX_H, $urandom_range(1, 48) << 16);
            write_reg(aabb_pkg::REG_OWN_IMASS, ($urandom_range(0, 3) == 0) ? 32'd0 :
                                     32'($urandom_range(1, 24'h04_0000)));
            write_reg(aabb_pkg::REG_MODE,
                      ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : 32'd1);
            phase(85);
            drain();
        end

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### files.f
sv/aabb_pkg.sv
sv/aabb_div.sv
sv/aabb_collision_impulse_step.sv
test/aabb_collision_impulse_step_tb.sv
